// ===== design/mexp_pkg.sv =====
`default_nettype none

package mexp_pkg;

    // Width of the base, exponent, modulus and result words.
    localparam int WIDTH = 32;

    // Bit counter for one serial pass over a word.
    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    // Smallest modulus that is used; register values below it are raised to it.
    localparam logic [WIDTH-1:0] MOD_MIN = WIDTH'(2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL
    } state_t;

endpackage

`default_nettype wire

// ===== design/modular_exponentiation_top.sv =====
`default_nettype none

// Modular exponentiation: power = base ** exponent mod modulus.
//
// Configuration: modulus is written at a rising edge with modulus_we high; the
// user must write it only while busy is low (unenforced). 0 or 1 is used as 2.
// Input: a word (base, exponent) is taken at a rising edge with start high and
// busy low. busy stays high until the result has been produced.
// Output: power is valid for exactly one cycle while done is high. The
// receiver cannot stall the block; the result must be captured on that cycle.
//
// Operation: the base is first reduced modulo the modulus by a serial shift and
// subtract over its bits. Each exponent bit up to the highest set bit then costs
// one check state and a serial squaring (none after the highest set bit), each
// set bit a serial multiply, and one last check state ends the scan. A zero
// exponent needs only the reduction and that last check state before done.
// A new item may be started in the cycle in which done is high.
// Reset returns the block to idle, sets the modulus register to 2 and discards
// any item in progress.

module modular_exponentiation_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      modulus_we,
    input  wire logic [mexp_pkg::WIDTH-1:0] modulus,
    input  wire logic                      start,
    input  wire logic [mexp_pkg::WIDTH-1:0] base,
    input  wire logic [mexp_pkg::WIDTH-1:0] exponent,
    output logic                           busy,
    output logic                           done,
    output logic [mexp_pkg::WIDTH-1:0]      power
);

    localparam int W = mexp_pkg::WIDTH;
    localparam int CW = mexp_pkg::CNT_W;

    mexp_pkg::state_t state_reg, state_next;

    // Configuration register and the modulus latched for the current item.
    logic [W-1:0]  mod_cfg_reg;
    logic [W-1:0]  m_reg, m_next;
    logic [W-1:0]  m_eff;

    // Serial datapath: multiplier shift register, partial result, operands.
    logic [W-1:0]  sh_reg, sh_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  e_reg, e_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          sqr_reg, sqr_next;
    logic          done_reg, done_next;
    logic [W-1:0]  power_reg, power_next;

    // Step results.
    logic [W:0]    red_t;
    logic [W-1:0]  red_r;
    logic [W:0]    dbl_t;
    logic [W-1:0]  dbl_r;
    logic [W:0]    add_t;
    logic [W-1:0]  add_r;
    logic [W-1:0]  mul_r;
    logic          last_bit;
    logic          e_high_zero;

    assign m_eff = (mod_cfg_reg < mexp_pkg::MOD_MIN) ? mexp_pkg::MOD_MIN : mod_cfg_reg;
    assign last_bit = (cnt_reg == '0);
    assign e_high_zero = (e_reg[W-1:1] == '0);

    // Reduction step: shift in the next base bit, subtract once if needed.
    always_comb
    begin
        red_t = {r_reg, sh_reg[W-1]};
        if (red_t >= {1'b0, m_reg})
        begin
            red_t = red_t - {1'b0, m_reg};
        end
        red_r = red_t[W-1:0];
    end

    // Multiply step: modular doubling, then a modular add of the base when
    // the current multiplier bit is set.
    always_comb
    begin
        dbl_t = {r_reg, 1'b0};
        if (dbl_t >= {1'b0, m_reg})
        begin
            dbl_t = dbl_t - {1'b0, m_reg};
        end
        dbl_r = dbl_t[W-1:0];
        add_t = {1'b0, dbl_r} + {1'b0, b_reg};
        if (add_t >= {1'b0, m_reg})
        begin
            add_t = add_t - {1'b0, m_reg};
        end
        add_r = add_t[W-1:0];
        mul_r = sh_reg[W-1] ? add_r : dbl_r;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = mexp_pkg::ST_REDUCE;
                end
            end
            mexp_pkg::ST_REDUCE:
            begin
                if (last_bit)
                begin
                    state_next = mexp_pkg::ST_CHECK;
                end
            end
            mexp_pkg::ST_CHECK:
            begin
                if (e_reg == '0)
                begin
                    state_next = mexp_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = mexp_pkg::ST_MUL;
                end
            end
            mexp_pkg::ST_MUL:
            begin
                if (last_bit && (sqr_reg || e_high_zero))
                begin
                    state_next = mexp_pkg::ST_CHECK;
                end
            end
            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        m_next     = m_reg;
        sh_next    = sh_reg;
        r_next     = r_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        e_next     = e_reg;
        cnt_next   = cnt_reg;
        sqr_next   = sqr_reg;
        done_next  = 1'b0;
        power_next = power_reg;
        unique case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    m_next   = m_eff;
                    sh_next  = base;
                    e_next   = exponent;
                    acc_next = W'(1);
                    r_next   = '0;
                    cnt_next = mexp_pkg::CNT_LAST;
                end
            end
            mexp_pkg::ST_REDUCE:
            begin
                r_next   = red_r;
                sh_next  = {sh_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (last_bit)
                begin
                    b_next = red_r;
                end
            end
            mexp_pkg::ST_CHECK:
            begin
                if (e_reg == '0)
                begin
                    power_next = acc_reg;
                    done_next  = 1'b1;
                end
                else
                begin
                    r_next   = '0;
                    cnt_next = mexp_pkg::CNT_LAST;
                    if (e_reg[0])
                    begin
                        sh_next  = acc_reg;
                        sqr_next = 1'b0;
                    end
                    else
                    begin
                        sh_next  = b_reg;
                        sqr_next = 1'b1;
                    end
                end
            end
            mexp_pkg::ST_MUL:
            begin
                r_next   = mul_r;
                sh_next  = {sh_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (last_bit)
                begin
                    if (sqr_reg)
                    begin
                        b_next = mul_r;
                        e_next = {1'b0, e_reg[W-1:1]};
                    end
                    else
                    begin
                        acc_next = mul_r;
                        if (e_high_zero)
                        begin
                            // Last set bit: the final squaring is not needed.
                            e_next = '0;
                        end
                        else
                        begin
                            sh_next  = b_reg;
                            r_next   = '0;
                            cnt_next = mexp_pkg::CNT_LAST;
                            sqr_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign busy  = (state_reg != mexp_pkg::ST_IDLE);
    assign done  = done_reg;
    assign power = power_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mexp_pkg::ST_IDLE;
            mod_cfg_reg <= mexp_pkg::MOD_MIN;
            cnt_reg     <= '0;
            sqr_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (modulus_we)
            begin
                mod_cfg_reg <= modulus;
            end
            cnt_reg  <= cnt_next;
            sqr_reg  <= sqr_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg     <= m_next;
        sh_reg    <= sh_next;
        r_reg     <= r_next;
        b_reg     <= b_next;
        acc_reg   <= acc_next;
        e_reg     <= e_next;
        power_reg <= power_next;
    end

    // A result is only produced from the check state with a zero exponent.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == mexp_pkg::ST_CHECK))
        else $error("result strobe without a finished exponent scan");

    // The partial product stays fully reduced throughout a multiply.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mexp_pkg::ST_MUL) |-> ((r_reg < m_reg) && (b_reg < m_reg)))
        else $error("multiply operand not reduced");

    // The working modulus is never below two while an item is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (m_reg >= mexp_pkg::MOD_MIN))
        else $error("working modulus below two");

    // An accepted word always makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done_reg))
        else $error("accepted word did not start processing");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;

    localparam int WIDTH = mexp_pkg::WIDTH;
    localparam logic [WIDTH-1:0] MOD_MIN = mexp_pkg::MOD_MIN;

    // The modulus register comes out of reset holding two.
    localparam logic [WIDTH-1:0] MODULUS_RESET = WIDTH'(2);
    localparam logic [WIDTH-1:0] ALL_ONES = {WIDTH{1'b1}};

    // The slowest word is one whose exponent is all ones. The watchdog is set
    // several times above what about 300 such words with the longest sender
    // gaps would take.
    localparam int WORD_CYCLES = 1 + 65 * WIDTH;
    localparam int CYCLE_LIMIT = 4_000_000;

    // The scoreboard keeps its own copy of the modulus register and holds one
    // predicted power per accepted word, oldest first.
    class power_scoreboard;
        logic [WIDTH-1:0] modulus_reg;
        logic [WIDTH-1:0] expected_powers[$];
        int errors;
        int words_taken;
        int powers_checked;
        int modulus_writes;

        function new();
            modulus_reg = MODULUS_RESET;
            errors = 0;
            words_taken = 0;
            powers_checked = 0;
            modulus_writes = 0;
        endfunction

        // Right-to-left square and multiply with exact double-width products.
        function logic [WIDTH-1:0] modpow(logic [WIDTH-1:0] b, logic [WIDTH-1:0] e,
                                          logic [WIDTH-1:0] m_reg);
            logic [2*WIDTH-1:0] m;
            logic [2*WIDTH-1:0] acc;
            logic [2*WIDTH-1:0] sq;
            logic [WIDTH-1:0] bits;
            m = (m_reg < MOD_MIN) ? (2*WIDTH)'(MOD_MIN) : (2*WIDTH)'(m_reg);
            sq = (2*WIDTH)'(b) % m;
            acc = (2*WIDTH)'(1);
            bits = e;
            while (bits != 0)
            begin
                if (bits[0])
                    acc = (acc * sq) % m;
                sq = (sq * sq) % m;
                bits = bits >> 1;
            end
            return acc[WIDTH-1:0];
        endfunction

        function void write_modulus(logic [WIDTH-1:0] value);
            modulus_reg = value;
            modulus_writes++;
        endfunction

        function void note_word(logic [WIDTH-1:0] b, logic [WIDTH-1:0] e);
            expected_powers.push_back(modpow(b, e, modulus_reg));
            words_taken++;
        endfunction

        function void check_power(logic [WIDTH-1:0] actual);
            logic [WIDTH-1:0] wanted;
            if (expected_powers.size() == 0)
            begin
                $display("%0t: power %h arrived with no word outstanding", $time, actual);
                errors++;
            end
            else
            begin
                wanted = expected_powers.pop_front();
                powers_checked++;
                if (actual !== wanted)
                begin
                    $display("%0t: power mismatch, expected %h, actual %h",
                             $time, wanted, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_powers.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             modulus_we;
    logic [WIDTH-1:0] modulus;
    logic             start;
    logic [WIDTH-1:0] base;
    logic [WIDTH-1:0] exponent;
    logic             busy;
    logic             done;
    logic [WIDTH-1:0] power;

    power_scoreboard sb = new();
    int cycle_count = 0;

    modular_exponentiation_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .modulus_we (modulus_we),
        .modulus    (modulus),
        .start      (start),
        .base       (base),
        .exponent   (exponent),
        .busy       (busy),
        .done       (done),
        .power      (power)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Everything the block does is observed at the rising edge. Inputs only
    // change at the falling edge, and the block's outputs are updated after
    // the edge, so the values read here are the ones the block itself saw.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (modulus_we)
                sb.write_modulus(modulus);
            if (start && !busy)
                sb.note_word(base, exponent);
            if (done)
                sb.check_power(power);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d powers outstanding",
                     $time, sb.pending());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Present one word and hold it until the block takes it. The task is entered
    // and left at a falling edge. When the gap is zero, start simply stays high
    // and the next word follows directly, which the block allows even in the
    // cycle in which it reports done.
    task automatic send_word(input logic [WIDTH-1:0] b, input logic [WIDTH-1:0] e,
                             input int gap);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        base = b;
        exponent = e;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Stop sending and wait until every predicted power has been seen.
    task automatic drain_powers();
        start = 1'b0;
        while (sb.pending() != 0 || busy)
            @(negedge clk);
    endtask

    // The modulus register is only written with the block idle, since every
    // word yields a power and nothing is still running once the queue is empty.
    task automatic set_modulus(input logic [WIDTH-1:0] value);
        drain_powers();
        modulus_we = 1'b1;
        modulus = value;
        @(negedge clk);
        modulus_we = 1'b0;
        modulus = $urandom;
    endtask

    // Sender gaps: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Bases lean toward the edges of the current modulus, where reduction of
    // the base matters most.
    function automatic logic [WIDTH-1:0] pick_base(input logic [WIDTH-1:0] m);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return WIDTH'(1);
            2: return m - 1;
            3: return m;
            4: return ALL_ONES;
            default: return $urandom;
        endcase
    endfunction

    // Exponents: mostly full random words, a share of short ones to keep the
    // run quick, and the corner values zero, one, all ones and single bits.
    function automatic logic [WIDTH-1:0] pick_exponent();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0: return '0;
            1: return WIDTH'(1);
            2: return ALL_ONES;
            3: return WIDTH'(1) << $urandom_range(0, WIDTH - 1);
            default:
            begin
                if (r < 9)
                    return WIDTH'($urandom_range(0, 255));
                return $urandom;
            end
        endcase
    endfunction

    initial
    begin
        logic [WIDTH-1:0] phase_moduli[10];
        logic [WIDTH-1:0] m;
        bit quiet_phase;
        int n_phase;

        rst_n = 1'b0;
        modulus_we = 1'b0;
        modulus = '0;
        start = 1'b0;
        base = '0;
        exponent = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part. First the reset modulus of two, untouched.
        send_word('0, '0, 0);
        send_word(WIDTH'(3), WIDTH'(5), 0);
        send_word(ALL_ONES, ALL_ONES, 2);

        // A register value of zero or one is used as two.
        set_modulus('0);
        send_word(WIDTH'(7), WIDTH'(3), 0);
        send_word('0, '0, 0);
        set_modulus(WIDTH'(1));
        send_word(WIDTH'(5), WIDTH'(9), 0);
        send_word(WIDTH'(4), WIDTH'(1), 1);

        // The widest modulus: products need the full double width here.
        set_modulus(ALL_ONES);
        send_word('0, '0, 0);
        send_word('0, WIDTH'(1), 0);
        send_word(ALL_ONES, WIDTH'(1), 0);
        send_word(ALL_ONES - 1, WIDTH'(2), 0);
        send_word(ALL_ONES - 1, ALL_ONES, 0);
        send_word(WIDTH'(1), ALL_ONES, 3);
        send_word(WIDTH'(2), WIDTH'(WIDTH - 1), 0);
        send_word(32'h8000_0000, 32'h8000_0000, 0);

        // A large prime just below the word limit; the base is reduced first
        // when it is not below the modulus.
        set_modulus(32'hFFFF_FFFB);
        send_word(32'hFFFF_FFFB, WIDTH'(3), 0);
        send_word(32'hFFFF_FFFC, WIDTH'(3), 0);
        send_word(ALL_ONES, 32'hFFFF_FFFA, 0);
        send_word(32'h1234_5678, 32'h5555_5555, 0);
        send_word(32'h8765_4321, 32'hAAAA_AAAA, 0);

        // Random part, in phases that each use one modulus setting.
        phase_moduli[0] = 32'hFFFF_FFFB;
        phase_moduli[1] = ALL_ONES;
        phase_moduli[2] = WIDTH'(3);
        phase_moduli[3] = 32'h8000_0000;
        phase_moduli[4] = $urandom;
        phase_moduli[5] = WIDTH'($urandom_range(2, 1000));
        phase_moduli[6] = $urandom | 32'h8000_0001;
        phase_moduli[7] = WIDTH'(65537);
        phase_moduli[8] = WIDTH'(1);
        phase_moduli[9] = $urandom;

        for (int p = 0; p < 10; p++)
        begin
            set_modulus(phase_moduli[p]);
            m = phase_moduli[p];
            // Every third phase runs back to back with no sender gaps.
            quiet_phase = (p % 3 == 1);
            n_phase = $urandom_range(24, 32);
            for (int i = 0; i < n_phase; i++)
            begin
                // Now and then the sender holds off until the block is empty.
                if ($urandom_range(0, 39) == 0)
                    drain_powers();
                send_word(pick_base(m), pick_exponent(), quiet_phase ? 0 : pick_gap());
            end
        end

        // Wait for the last powers, then watch a while longer for stray strobes.
        drain_powers();
        repeat (WORD_CYCLES) @(negedge clk);

        $display("Sent %0d words over %0d modulus writes; %0d powers checked.",
                 sb.words_taken, sb.modulus_writes, sb.powers_checked);
        $display("Moduli covered zero, one, two, small, random and full-width values.");
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("%0d errors, %0d powers never arrived", sb.errors, sb.pending());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== modular_exponentiation_top.f =====
design/mexp_pkg.sv
design/modular_exponentiation_top.sv
tb/tb_top.sv
